// File: design/assert_macros.svh
// Assertion macros shared by the curve evaluator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RBCE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RBCE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rbce_pkg.sv
// Package for the rational B-spline curve evaluator: item types, codes and constants.
// Saturation and magnitude helpers used by the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbce_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int MAX_DEGREE_DEF = 7;
    localparam int MAX_KNOTS_DEF  = 40;

    localparam int DIV_NW = 96;
    localparam int DIV_DW = 64;

    localparam logic [1:0] KIND_KNOT  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [1:0] REG_DEGREE     = 2'd0;
    localparam logic [1:0] REG_NUM_POINTS = 2'd1;
    localparam logic [1:0] REG_NUM_KNOTS  = 2'd2;
    localparam logic [1:0] REG_RATIONAL   = 2'd3;

    localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
    localparam logic [63:0]        WSUM_EPS = 64'd429496;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         index;
        logic signed [31:0] knot_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [31:0]        point_weight;
        logic signed [31:0] param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic signed [31:0] curve_z;
        logic               weight_fallback;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        w;
    } point_t;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        abs33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        abs64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Quotient magnitude with sign applied, saturated to 32 bits.
    function automatic logic signed [31:0] sat_q(input logic [DIV_NW-1:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            r = (q > DIV_NW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q[31:0]);
        end
        else
        begin
            r = (q > DIV_NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q[31:0]);
        end
        sat_q = r;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        sat64 = r;
    endfunction

endpackage

`default_nettype wire

// File: design/rbce_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on rbce_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rbce_div
    import rbce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic                   busy,
    output logic [DIV_NW-1:0]      quo
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   rem_shift;
    logic [DIV_DW:0]   rem_diff;
    logic              take;

    assign rem_shift = {rem_reg, quo_reg[DIV_NW-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign take      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DIV_NW);
            quo_reg  <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? rem_diff[DIV_DW-1:0] : rem_shift[DIV_DW-1:0];
            quo_reg  <= {quo_reg[DIV_NW-2:0], take};
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: design/rational_bspline_curve_evaluate.sv
// Flow: a load item is written while the block stays idle; an evaluate item runs, for each
// level k from 1 to degree, points + degree - k basis terms with up to two divisions each,
// plus one division per control point in rational mode unless the weight sum falls back, all on the shared divider.
// Throughput: after an evaluate item the input is not ready until its result is registered; load items leave it ready.
// Reset: asynchronous, active low; registers return to degree 3, four points, eight knots,
// plain mode. Knot and point tables are not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rational_bspline_curve_evaluate
    import rbce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int MAX_KNOTS  = MAX_KNOTS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    localparam int BD  = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KAW = $clog2(MAX_KNOTS);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int BAW = $clog2(BD);
    localparam int IW  = $clog2(MAX_POINTS + MAX_DEGREE + MAX_KNOTS + 64);

    typedef enum logic [5:0] {
        S_IDLE, S_RD_T0, S_RD_TL, S_CAP_TL, S_Z0, S_Z1, S_Z2,
        S_R_CHK, S_R_K0, S_R_K1, S_R_K2, S_R_K3, S_R_K4, S_R_B,
        S_R_AM, S_R_AD, S_R_AW, S_R_BM, S_R_BD, S_R_BW, S_R_SUM,
        S_W0, S_W1, S_W2, S_W_CHK,
        S_O0, S_O1, S_O_WD, S_O_WW, S_O_MX, S_O_MY, S_O_MZ, S_O_MA, S_FIN
    } state_t;

    state_t state_reg;

    logic [2:0] degree_reg;
    logic [5:0] num_points_reg;
    logic [5:0] num_knots_reg;
    logic       rational_reg;

    logic signed [31:0] knot_mem [MAX_KNOTS];
    point_t             point_mem [MAX_POINTS];
    logic signed [31:0] basis_mem [BD];
    logic signed [31:0] knot_rd_reg;
    point_t             point_rd_reg;
    logic signed [31:0] basis_rd_reg;

    logic [IW-1:0] d_reg, np_reg, last_reg, cnt_reg, i_reg, k_reg;
    logic signed [31:0] t_reg, t0_reg, tl_reg;
    logic signed [31:0] ka_reg, kb_reg, kc_reg, kd_reg;
    logic signed [31:0] ba_reg, bb_reg, a_reg, b_reg;
    point_t             pt_reg;
    logic               neg_reg;
    logic signed [63:0] w_reg, accx_reg, accy_reg, accz_reg, prod_reg;
    logic               fallback_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [IW-1:0] d_start, np_start, nk_clamp, nk_start;
    logic [IW-1:0] knot_sel, knot_clamp, basis_sel;
    logic [KAW-1:0] knot_raddr;
    logic signed [32:0] num_a, num_b, den_a, den_b;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [63:0] bw;
    logic               in_fire, z_one, div_start, div_busy;
    logic [DIV_NW-1:0]  div_num, div_quo;
    logic [DIV_DW-1:0]  div_den;
    logic signed [32:0] term_sum;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= 3'd3;
            num_points_reg <= 6'd4;
            num_knots_reg  <= 6'd8;
            rational_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEGREE:     degree_reg     <= cfg_data[2:0];
                REG_NUM_POINTS: num_points_reg <= cfg_data;
                REG_NUM_KNOTS:  num_knots_reg  <= cfg_data;
                REG_RATIONAL:   rational_reg   <= cfg_data[0];
                default:        rational_reg   <= rational_reg;
            endcase
        end
    end

    assign d_start  = (IW'(degree_reg) > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : IW'(degree_reg);
    assign np_start = (IW'(num_points_reg) > IW'(MAX_POINTS)) ?
                      IW'(MAX_POINTS) : IW'(num_points_reg);
    assign nk_clamp = (IW'(num_knots_reg) > IW'(MAX_KNOTS)) ?
                      IW'(MAX_KNOTS) : IW'(num_knots_reg);
    assign nk_start = (nk_clamp == '0) ? IW'(1) : nk_clamp;

    always_comb
    begin
        case (state_reg)
            S_RD_TL: knot_sel = last_reg;
            S_Z0:    knot_sel = i_reg;
            S_Z1:    knot_sel = i_reg + IW'(1);
            S_R_K0:  knot_sel = i_reg;
            S_R_K1:  knot_sel = i_reg + IW'(1);
            S_R_K2:  knot_sel = i_reg + k_reg;
            S_R_K3:  knot_sel = i_reg + k_reg + IW'(1);
            default: knot_sel = '0;
        endcase
        case (state_reg)
            S_R_K4:  basis_sel = i_reg + IW'(1);
            default: basis_sel = i_reg;
        endcase
    end

    assign knot_clamp = (knot_sel > last_reg) ? last_reg : knot_sel;
    assign knot_raddr = knot_clamp[KAW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.kind == KIND_KNOT && int'(in_data.index) < MAX_KNOTS)
        begin
            knot_mem[KAW'(in_data.index)] <= in_data.knot_value;
        end
        knot_rd_reg <= knot_mem[knot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.kind == KIND_POINT && int'(in_data.index) < MAX_POINTS)
        begin
            point_mem[PAW'(in_data.index)] <= '{x: in_data.point_x, y: in_data.point_y,
                                                z: in_data.point_z, w: in_data.point_weight};
        end
        point_rd_reg <= point_mem[i_reg[PAW-1:0]];
    end

    assign z_one = (t_reg >= ka_reg && t_reg < knot_rd_reg) ||
                   (t_reg <= t0_reg && ka_reg <= t0_reg) ||
                   (t_reg >= tl_reg && knot_rd_reg >= tl_reg);
    assign term_sum = {a_reg[31], a_reg} + {b_reg[31], b_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_Z2)
        begin
            basis_mem[i_reg[BAW-1:0]] <= z_one ? ONE_Q30 : 32'sd0;
        end
        else if (state_reg == S_R_SUM)
        begin
            basis_mem[i_reg[BAW-1:0]] <= sat64(64'(term_sum));
        end
        basis_rd_reg <= basis_mem[basis_sel[BAW-1:0]];
    end

    assign num_a = {t_reg[31], t_reg} - {ka_reg[31], ka_reg};
    assign den_a = {kc_reg[31], kc_reg} - {ka_reg[31], ka_reg};
    assign num_b = {kd_reg[31], kd_reg} - {t_reg[31], t_reg};
    assign den_b = {kd_reg[31], kd_reg} - {kb_reg[31], kb_reg};
    assign bw    = prod_reg >>> 14;

    always_comb
    begin
        case (state_reg)
            S_R_AM:
            begin
                mul_a = {1'b0, abs33({ba_reg[31], ba_reg})};
                mul_b = {1'b0, abs33(num_a)};
            end
            S_R_BM:
            begin
                mul_a = {1'b0, abs33({bb_reg[31], bb_reg})};
                mul_b = {1'b0, abs33(num_b)};
            end
            S_W1, S_O1:
            begin
                mul_a = 34'(basis_rd_reg);
                mul_b = {2'b00, point_rd_reg.w};
            end
            S_O_MX:
            begin
                mul_a = 34'(pt_reg.x);
                mul_b = 34'(ba_reg);
            end
            S_O_MY:
            begin
                mul_a = 34'(pt_reg.y);
                mul_b = 34'(ba_reg);
            end
            default:
            begin
                mul_a = 34'(pt_reg.z);
                mul_b = 34'(ba_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[63:0];
    end

    always_comb
    begin
        case (state_reg)
            S_R_AD:
            begin
                div_num = DIV_NW'(prod_reg);
                div_den = DIV_DW'(abs33(den_a));
            end
            S_R_BD:
            begin
                div_num = DIV_NW'(prod_reg);
                div_den = DIV_DW'(abs33(den_b));
            end
            default:
            begin
                div_num = {2'b00, abs64(bw), 30'd0};
                div_den = abs64(w_reg);
            end
        endcase
    end

    assign div_start = (state_reg == S_R_AD) || (state_reg == S_R_BD) ||
                       (state_reg == S_O_WD);

    rbce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_data.kind == KIND_EVAL)
                    begin
                        t_reg        <= in_data.param_t;
                        d_reg        <= d_start;
                        np_reg       <= np_start;
                        last_reg     <= nk_start - IW'(1);
                        cnt_reg      <= np_start + d_start;
                        w_reg        <= '0;
                        accx_reg     <= '0;
                        accy_reg     <= '0;
                        accz_reg     <= '0;
                        fallback_reg <= 1'b0;
                        state_reg    <= S_RD_T0;
                    end
                end
                S_RD_T0:  state_reg <= S_RD_TL;
                S_RD_TL:
                begin
                    t0_reg    <= knot_rd_reg;
                    state_reg <= S_CAP_TL;
                end
                S_CAP_TL:
                begin
                    tl_reg    <= knot_rd_reg;
                    i_reg     <= '0;
                    state_reg <= S_Z0;
                end
                S_Z0:
                begin
                    if (i_reg >= cnt_reg)
                    begin
                        i_reg     <= '0;
                        k_reg     <= IW'(1);
                        state_reg <= S_R_CHK;
                    end
                    else
                    begin
                        state_reg <= S_Z1;
                    end
                end
                S_Z1:
                begin
                    ka_reg    <= knot_rd_reg;
                    state_reg <= S_Z2;
                end
                S_Z2:
                begin
                    i_reg     <= i_reg + IW'(1);
                    state_reg <= S_Z0;
                end
                S_R_CHK:
                begin
                    if (k_reg > d_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= rational_reg ? S_W0 : S_O0;
                    end
                    else if (i_reg + k_reg >= cnt_reg)
                    begin
                        i_reg <= '0;
                        k_reg <= k_reg + IW'(1);
                    end
                    else
                    begin
                        state_reg <= S_R_K0;
                    end
                end
                S_R_K0: state_reg <= S_R_K1;
                S_R_K1:
                begin
                    ka_reg    <= knot_rd_reg;
                    state_reg <= S_R_K2;
                end
                S_R_K2:
                begin
                    kb_reg    <= knot_rd_reg;
                    state_reg <= S_R_K3;
                end
                S_R_K3:
                begin
                    kc_reg    <= knot_rd_reg;
                    state_reg <= S_R_K4;
                end
                S_R_K4:
                begin
                    kd_reg    <= knot_rd_reg;
                    ba_reg    <= basis_rd_reg;
                    state_reg <= S_R_B;
                end
                S_R_B:
                begin
                    bb_reg    <= basis_rd_reg;
                    state_reg <= S_R_AM;
                end
                S_R_AM:
                begin
                    neg_reg <= ba_reg[31] ^ num_a[32] ^ den_a[32];
                    if (kc_reg == ka_reg)
                    begin
                        a_reg     <= '0;
                        state_reg <= S_R_BM;
                    end
                    else
                    begin
                        state_reg <= S_R_AD;
                    end
                end
                S_R_AD: state_reg <= S_R_AW;
                S_R_AW:
                begin
                    if (!div_busy)
                    begin
                        a_reg     <= sat_q(div_quo, neg_reg);
                        state_reg <= S_R_BM;
                    end
                end
                S_R_BM:
                begin
                    neg_reg <= bb_reg[31] ^ num_b[32] ^ den_b[32];
                    if (kd_reg == kb_reg)
                    begin
                        b_reg     <= '0;
                        state_reg <= S_R_SUM;
                    end
                    else
                    begin
                        state_reg <= S_R_BD;
                    end
                end
                S_R_BD: state_reg <= S_R_BW;
                S_R_BW:
                begin
                    if (!div_busy)
                    begin
                        b_reg     <= sat_q(div_quo, neg_reg);
                        state_reg <= S_R_SUM;
                    end
                end
                S_R_SUM:
                begin
                    i_reg     <= i_reg + IW'(1);
                    state_reg <= S_R_CHK;
                end
                S_W0:     state_reg <= (i_reg >= np_reg) ? S_W_CHK : S_W1;
                S_W1:     state_reg <= S_W2;
                S_W2:
                begin
                    w_reg     <= w_reg + bw;
                    i_reg     <= i_reg + IW'(1);
                    state_reg <= S_W0;
                end
                S_W_CHK:
                begin
                    fallback_reg <= !(abs64(w_reg) > WSUM_EPS);
                    i_reg        <= '0;
                    state_reg    <= S_O0;
                end
                S_O0:     state_reg <= (i_reg >= np_reg) ? S_FIN : S_O1;
                S_O1:
                begin
                    ba_reg    <= basis_rd_reg;
                    pt_reg    <= point_rd_reg;
                    state_reg <= (rational_reg && !fallback_reg) ? S_O_WD : S_O_MX;
                end
                S_O_WD:
                begin
                    neg_reg   <= bw[63] ^ w_reg[63];
                    state_reg <= S_O_WW;
                end
                S_O_WW:
                begin
                    if (!div_busy)
                    begin
                        ba_reg    <= sat_q(div_quo, neg_reg);
                        state_reg <= S_O_MX;
                    end
                end
                S_O_MX:   state_reg <= S_O_MY;
                S_O_MY:
                begin
                    accx_reg  <= accx_reg + bw;
                    state_reg <= S_O_MZ;
                end
                S_O_MZ:
                begin
                    accy_reg  <= accy_reg + bw;
                    state_reg <= S_O_MA;
                end
                S_O_MA:
                begin
                    accz_reg  <= accz_reg + bw;
                    i_reg     <= i_reg + IW'(1);
                    state_reg <= S_O0;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.curve_x         <= sat64(accx_reg >>> 16);
                        out_reg.curve_y         <= sat64(accy_reg >>> 16);
                        out_reg.curve_z         <= sat64(accz_reg >>> 16);
                        out_reg.weight_fallback <= rational_reg && fallback_reg;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `RBCE_ASSERT_SAME(a_div_idle_in_ready, clk, rst_n, in_ready, !div_busy,
        "divider busy while the block takes items")
    `RBCE_ASSERT_SAME(a_div_busy_wait, clk, rst_n, div_busy,
        state_reg == S_R_AW || state_reg == S_R_BW || state_reg == S_O_WW,
        "divider busy outside a wait state")
    `RBCE_ASSERT_SAME(a_fallback_rational, clk, rst_n, out_valid && out_data.weight_fallback,
        rational_reg, "weight fallback flagged in plain mode")
    `RBCE_ASSERT_NEXT(a_eval_blocks_input, clk, rst_n,
        in_valid && in_ready && in_data.kind == KIND_EVAL, !in_ready,
        "input still ready after an evaluate item")

endmodule

`default_nettype wire
